// File: sv/hashed_write_back_record_cache_defines.svh
// ----------------------------------------------------------------------------
// Hashed write-back record cache: assertion macros
// Shared assertion forms for the cache modules, clocked on clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef HASHED_WRITE_BACK_RECORD_CACHE_DEFINES_SVH
`define HASHED_WRITE_BACK_RECORD_CACHE_DEFINES_SVH

// Same-cycle implication.
`define HWBRC_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hwbrc assertion failed");

// Next-cycle implication.
`define HWBRC_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hwbrc assertion failed");

`endif

// File: sv/hwbrc_pkg.sv
// ----------------------------------------------------------------------------
// Hashed write-back record cache package
// Types, codes and constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package hwbrc_pkg;

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  localparam logic [2:0] KIND_READ_HIT   = 3'd0;
  localparam logic [2:0] KIND_READ_MISS  = 3'd1;
  localparam logic [2:0] KIND_WRITE_DONE = 3'd2;
  localparam logic [2:0] KIND_WRITEBACK  = 3'd3;
  localparam logic [2:0] KIND_FLUSH_NONE = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_MOD, S_RD, S_EV, S_WB, S_OUTW, S_WR,
    S_FNEXT, S_OUTF, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    RES_HOLD, RES_HIT, RES_MISS, RES_WB0, RES_DONE, RES_PEND_MID,
    RES_PEND_END, RES_FNONE
  } res_sel_t;

  typedef struct packed {
    logic        filled;
    logic        dirty;
    logic [3:0]  tab;
    logic [63:0] rec;
    logic [63:0] key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] key;
    logic [63:0] rec;
    logic [3:0]  tab;
    logic        last;
  } result_t;

  typedef struct packed {
    logic     in_ready;
    logic     clr_write;
    logic     hash_step;
    logic     mod_step;
    logic     rd;
    logic     note;
    logic     tgt_cur;
    logic     next_way;
    logic     wr_rec;
    logic     wr_clean;
    logic     pend_load;
    res_sel_t res_sel;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic       in_take;
    logic [1:0] in_func;
    logic       bidx_ok;
    logic [1:0] func;
    logic       clr_last;
    logic       hash_last;
    logic       mod_last;
    logic       way_last;
    logic       key_eq;
    logic       free_any;
    logic       filled;
    logic       dirty;
    logic       pend_v;
    logic       out_free;
  } sts_t;

endpackage

// File: sv/hwbrc_ram.sv
// ----------------------------------------------------------------------------
// Hashed write-back record cache: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hwbrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/hwbrc_ctrl.sv
// ----------------------------------------------------------------------------
// Hashed write-back record cache: controller
// Sequences clearing, hashing, bucket reduction, way scan and result output.
// ----------------------------------------------------------------------------
`include "hashed_write_back_record_cache_defines.svh"

module hwbrc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  hwbrc_pkg::sts_t sts,
  output hwbrc_pkg::cmd_t cmd
);

  hwbrc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hwbrc_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.res_sel = hwbrc_pkg::RES_HOLD;
    unique case (state_r)
      hwbrc_pkg::S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_nxt = hwbrc_pkg::S_IDLE;
      end
      hwbrc_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_take) begin
          case (sts.in_func) inside
            hwbrc_pkg::FUNC_WRITE, hwbrc_pkg::FUNC_READ: state_nxt = hwbrc_pkg::S_HASH;
            hwbrc_pkg::FUNC_FLUSH: begin
              if (sts.bidx_ok) begin
                state_nxt = hwbrc_pkg::S_RD;
              end else begin
                cmd.res_sel = hwbrc_pkg::RES_FNONE;
                state_nxt   = hwbrc_pkg::S_OUT;
              end
            end
            default: state_nxt = hwbrc_pkg::S_IDLE;
          endcase
        end
      end
      hwbrc_pkg::S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) state_nxt = hwbrc_pkg::S_MOD;
      end
      hwbrc_pkg::S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = hwbrc_pkg::S_RD;
      end
      hwbrc_pkg::S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = hwbrc_pkg::S_EV;
      end
      hwbrc_pkg::S_EV: begin
        case (sts.func)
          hwbrc_pkg::FUNC_WRITE: begin
            if (sts.key_eq) begin
              cmd.tgt_cur = 1'b1;
              state_nxt   = hwbrc_pkg::S_WR;
            end else begin
              cmd.note = 1'b1;
              if (sts.way_last) begin
                state_nxt = sts.free_any ? hwbrc_pkg::S_WR : hwbrc_pkg::S_WB;
              end else begin
                cmd.next_way = 1'b1;
                state_nxt    = hwbrc_pkg::S_RD;
              end
            end
          end
          hwbrc_pkg::FUNC_READ: begin
            if (sts.key_eq) begin
              cmd.res_sel = sts.filled ? hwbrc_pkg::RES_HIT : hwbrc_pkg::RES_MISS;
              state_nxt   = hwbrc_pkg::S_OUT;
            end else if (sts.way_last) begin
              cmd.res_sel = hwbrc_pkg::RES_MISS;
              state_nxt   = hwbrc_pkg::S_OUT;
            end else begin
              cmd.next_way = 1'b1;
              state_nxt    = hwbrc_pkg::S_RD;
            end
          end
          default: begin
            if (sts.dirty) begin
              cmd.wr_clean  = 1'b1;
              cmd.pend_load = 1'b1;
              if (sts.pend_v) begin
                cmd.res_sel = hwbrc_pkg::RES_PEND_MID;
                state_nxt   = hwbrc_pkg::S_OUTF;
              end else begin
                state_nxt = hwbrc_pkg::S_FNEXT;
              end
            end else begin
              state_nxt = hwbrc_pkg::S_FNEXT;
            end
          end
        endcase
      end
      hwbrc_pkg::S_WB: begin
        cmd.res_sel = hwbrc_pkg::RES_WB0;
        state_nxt   = hwbrc_pkg::S_OUTW;
      end
      hwbrc_pkg::S_OUTW: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = hwbrc_pkg::S_WR;
        end
      end
      hwbrc_pkg::S_WR: begin
        cmd.wr_rec  = 1'b1;
        cmd.res_sel = hwbrc_pkg::RES_DONE;
        state_nxt   = hwbrc_pkg::S_OUT;
      end
      hwbrc_pkg::S_FNEXT: begin
        if (sts.way_last) begin
          cmd.res_sel = sts.pend_v ? hwbrc_pkg::RES_PEND_END : hwbrc_pkg::RES_FNONE;
          state_nxt   = hwbrc_pkg::S_OUT;
        end else begin
          cmd.next_way = 1'b1;
          state_nxt    = hwbrc_pkg::S_RD;
        end
      end
      hwbrc_pkg::S_OUTF: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = hwbrc_pkg::S_FNEXT;
        end
      end
      hwbrc_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = hwbrc_pkg::S_IDLE;
        end
      end
      default: state_nxt = hwbrc_pkg::S_CLEAR;
    endcase
  end

  `HWBRC_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free)
  `HWBRC_ASSERT_NXT(a_rd_then_ev, state_r == hwbrc_pkg::S_RD, state_r == hwbrc_pkg::S_EV)
  `HWBRC_ASSERT_NXT(a_clear_done, (state_r == hwbrc_pkg::S_CLEAR) && sts.clr_last, state_r == hwbrc_pkg::S_IDLE)

endmodule

// File: sv/hwbrc_dp.sv
// ----------------------------------------------------------------------------
// Hashed write-back record cache: datapath
// Request registers, FNV-1 hash, bucket remainder, way store and result path.
// ----------------------------------------------------------------------------
module hwbrc_dp #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  hwbrc_pkg::cmd_t cmd,
  output hwbrc_pkg::sts_t sts,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [143:0]    in_tdata,
  input  logic [1:0]      in_tuser,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [135:0]    out_tdata,
  output logic [2:0]      out_tuser,
  output logic            out_tlast
);

  localparam int SLOTS = BUCKETS * WAYS;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BAW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int BL    = $clog2(BUCKETS);
  // Rounded-up reciprocal of BUCKETS scaled by 2^(32+BL); exact for 32-bit hashes.
  localparam logic [63:0] RECIP =
    ((64'd1 << (32 + BL)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

  logic [1:0]         func_r;
  logic [63:0]        key_r;
  logic [63:0]        rec_r;
  logic [3:0]         tab_r;
  logic [31:0]        h_r;
  logic [2:0]         cnt_r;
  logic [64:0]        prod_r;
  logic [BAW-1:0]     bucket_r;
  logic [WW-1:0]      way_r;
  logic [WW-1:0]      tgt_r;
  logic               free_v_r;
  logic               pend_v_r;
  hwbrc_pkg::entry_t  way0_r;
  hwbrc_pkg::entry_t  pend_r;
  logic [AW-1:0]      clr_addr_r;
  hwbrc_pkg::result_t res_r;
  hwbrc_pkg::result_t out_r;
  logic               out_valid_r;

  logic                      take;
  logic                      free_cond;
  logic [64:0]               prod_nxt;
  logic [AW-1:0]             base_way_addr;
  logic [AW-1:0]             tgt_addr;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  hwbrc_pkg::entry_t         ram_wdata;
  logic [hwbrc_pkg::ENTRY_W-1:0] ram_rbits;
  hwbrc_pkg::entry_t         rdata;

  assign take      = in_tvalid && cmd.in_ready;
  assign in_tready = cmd.in_ready;
  assign rdata     = hwbrc_pkg::entry_t'(ram_rbits);
  assign free_cond = (rdata.key == 64'd0) || !rdata.dirty;

  assign base_way_addr = AW'(32'(bucket_r) * 32'(WAYS) + 32'(way_r));
  assign tgt_addr      = AW'(32'(bucket_r) * 32'(WAYS) + 32'(tgt_r));

  assign prod_nxt = {1'b0, 64'(h_r) * 64'(RECIP[31:0])}
                  + (RECIP[32] ? {1'b0, h_r, 32'd0} : 65'd0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base_way_addr;
    ram_wdata = rdata;
    if (cmd.clr_write) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (cmd.wr_rec) begin
      ram_we    = 1'b1;
      ram_waddr = tgt_addr;
      ram_wdata = '{filled: 1'b1, dirty: 1'b1, tab: tab_r, rec: rec_r, key: key_r};
    end else if (cmd.wr_clean) begin
      ram_we          = 1'b1;
      ram_wdata.dirty = 1'b0;
    end
  end

  hwbrc_ram #(
    .WIDTH (hwbrc_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (base_way_addr),
    .rdata (ram_rbits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      free_v_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      way_r       <= '0;
    end else begin
      if (cmd.clr_write) clr_addr_r <= clr_addr_r + AW'(1);
      if (take) begin
        free_v_r <= 1'b0;
        pend_v_r <= 1'b0;
        cnt_r    <= '0;
        way_r    <= '0;
      end else begin
        if (cmd.hash_step || cmd.mod_step) cnt_r <= cnt_r + 3'd1;
        if (cmd.next_way) way_r <= way_r + WW'(1);
        if (cmd.note && !free_v_r && free_cond) free_v_r <= 1'b1;
        if (cmd.pend_load) pend_v_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      func_r   <= in_tuser;
      key_r    <= in_tdata[63:0];
      rec_r    <= in_tdata[127:64];
      tab_r    <= in_tdata[131:128];
      bucket_r <= BAW'(in_tdata[139:132]);
      h_r      <= hwbrc_pkg::FNV_OFFSET;
      tgt_r    <= '0;
    end
    if (cmd.hash_step) begin
      h_r <= 32'(h_r * hwbrc_pkg::FNV_PRIME) ^ {24'd0, key_r[{cnt_r, 3'b000} +: 8]};
    end
    if (cmd.mod_step) begin
      if (cnt_r == 3'd0) begin
        prod_r <= prod_nxt;
      end else begin
        bucket_r <= h_r[BAW-1:0] - BAW'(prod_r[32+BL +: BAW] * BAW'(BUCKETS));
      end
    end
    if (cmd.tgt_cur) tgt_r <= way_r;
    if (cmd.note) begin
      if (way_r == '0) way0_r <= rdata;
      if (!free_v_r && free_cond) tgt_r <= way_r;
    end
    if (cmd.pend_load) pend_r <= rdata;
    case (cmd.res_sel)
      hwbrc_pkg::RES_HIT:
        res_r <= '{kind: hwbrc_pkg::KIND_READ_HIT, key: key_r, rec: rdata.rec,
                   tab: 4'd0, last: 1'b1};
      hwbrc_pkg::RES_MISS:
        res_r <= '{kind: hwbrc_pkg::KIND_READ_MISS, key: 64'd0, rec: 64'd0,
                   tab: 4'd0, last: 1'b1};
      hwbrc_pkg::RES_WB0:
        res_r <= '{kind: hwbrc_pkg::KIND_WRITEBACK, key: way0_r.key, rec: way0_r.rec,
                   tab: way0_r.tab, last: 1'b0};
      hwbrc_pkg::RES_DONE:
        res_r <= '{kind: hwbrc_pkg::KIND_WRITE_DONE, key: 64'd0, rec: 64'd0,
                   tab: 4'd0, last: 1'b1};
      hwbrc_pkg::RES_PEND_MID:
        res_r <= '{kind: hwbrc_pkg::KIND_WRITEBACK, key: pend_r.key, rec: pend_r.rec,
                   tab: pend_r.tab, last: 1'b0};
      hwbrc_pkg::RES_PEND_END:
        res_r <= '{kind: hwbrc_pkg::KIND_WRITEBACK, key: pend_r.key, rec: pend_r.rec,
                   tab: pend_r.tab, last: 1'b1};
      hwbrc_pkg::RES_FNONE:
        res_r <= '{kind: hwbrc_pkg::KIND_FLUSH_NONE, key: 64'd0, rec: 64'd0,
                   tab: 4'd0, last: 1'b1};
      default: res_r <= res_r;
    endcase
    if (cmd.emit) out_r <= res_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.tab, out_r.rec, out_r.key};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

  always_comb begin
    sts           = '0;
    sts.in_take   = take;
    sts.in_func   = in_tuser;
    sts.bidx_ok   = {24'd0, in_tdata[139:132]} < 32'(BUCKETS);
    sts.func      = func_r;
    sts.clr_last  = clr_addr_r == AW'(SLOTS - 1);
    sts.hash_last = cnt_r == 3'd7;
    sts.mod_last  = cnt_r == 3'd1;
    sts.way_last  = way_r == WW'(WAYS - 1);
    sts.key_eq    = rdata.key == key_r;
    sts.free_any  = free_v_r || free_cond;
    sts.filled    = rdata.filled;
    sts.dirty     = rdata.dirty;
    sts.pend_v    = pend_v_r;
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

// File: sv/hashed_write_back_record_cache.sv
// ----------------------------------------------------------------------------
// Hashed write-back record cache
// Set-associative write-back cache of 64-bit records keyed by an FNV-1 hash.
// ----------------------------------------------------------------------------
// After reset the block sweeps its way store, one entry per cycle, and
// accepts no request until that is done. It then handles one request at
// a time. A read or write first hashes the eight key bytes (one 32-bit
// multiply per cycle), then forms the bucket remainder (a reciprocal
// multiply, then a low-bit correction), then reads and evaluates each
// scanned way on the single read port of the way store; a write then
// stores its record, and the results are presented. A flush skips the
// hash and reads, evaluates and steps past each way of its bucket in turn.
// Results wait in an output register; a stalled output holds up the scan.
module hashed_write_back_record_cache #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // lookup_key[63:0], record_word[127:64], table_id[131:128],
  // bucket_index[139:132], zero fill
  input  logic [143:0] in_tdata,
  // func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_key[63:0], out_record[127:64], out_table[131:128], zero fill
  output logic [135:0] out_tdata,
  // kind
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  hwbrc_pkg::cmd_t cmd;
  hwbrc_pkg::sts_t sts;

  hwbrc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  hwbrc_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
